[hw/rtl/iplpm_pkg.sv]
// shared types and constants for the ipv4 longest prefix route lookup unit
// no dependencies
`default_nettype none

package iplpm_pkg;

    localparam int ROUTES = 1024;
    localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNT_W  = $clog2(ROUTES + 1);
    localparam int ACT_W  = 11;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  entry_index;
        logic [31:0] route_prefix;
        logic [31:0] route_mask;
        logic [31:0] route_gateway;
        logic [7:0]  route_port;
        logic [31:0] dest_address;
    } t_in_req;

    typedef struct packed {
        logic        route_found;
        logic [31:0] hop_addr;
        logic [7:0]  out_port;
    } t_result;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [7:0]  port;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             start;
        logic [31:0]      dest;
        logic [CNT_W-1:0] limit;
    } t_scan_req;

endpackage

`default_nettype wire

[hw/rtl/iplpm_table.sv]
// route table memory, one write port and one registered read port
// depends on iplpm_pkg
`default_nettype none

module iplpm_table (
    input  wire                           i_clk,
    input  wire                           i_wr_en,
    input  wire  [iplpm_pkg::IDX_W-1:0]   i_wr_addr,
    input  wire  iplpm_pkg::t_entry       i_wr_data,
    input  wire  iplpm_pkg::t_rd_req      i_rd,
    output iplpm_pkg::t_entry             o_rd_data
);

    iplpm_pkg::t_entry mem [iplpm_pkg::ROUTES];
    iplpm_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/iplpm_scan.sv]
// lookup sequencer: walks the table one entry per cycle, keeps the best match
// and holds the result register; depends on iplpm_pkg
`default_nettype none

module iplpm_scan (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  iplpm_pkg::t_scan_req i_req,
    output logic                      o_busy,
    output iplpm_pkg::t_rd_req        o_rd,
    input  wire  iplpm_pkg::t_entry   i_rd_data,
    output logic                      o_res_valid,
    input  wire                       i_res_ready,
    output iplpm_pkg::t_result        o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_scan_state;

    t_scan_state                   r_state, n_state;
    logic                          r_cmp_v, n_cmp_v;
    logic                          r_out_valid, n_out_valid;
    iplpm_pkg::t_result            r_out, n_out;
    logic [31:0]                   r_dest, n_dest;
    logic [iplpm_pkg::CNT_W-1:0]   r_limit, n_limit;
    logic [iplpm_pkg::CNT_W-1:0]   r_addr, n_addr;
    logic                          r_found, n_found;
    logic [31:0]                   r_mask, n_mask;
    logic [31:0]                   r_hop, n_hop;
    logic [7:0]                    r_port, n_port;
    logic                          match;
    logic                          better;

    assign match  = (r_dest & i_rd_data.mask) == i_rd_data.prefix;
    assign better = !r_found || (i_rd_data.mask > r_mask);

    always_comb begin
        n_state     = r_state;
        n_cmp_v     = r_cmp_v;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_dest      = r_dest;
        n_limit     = r_limit;
        n_addr      = r_addr;
        n_found     = r_found;
        n_mask      = r_mask;
        n_hop       = r_hop;
        n_port      = r_port;
        o_rd.en     = 1'b0;
        o_rd.addr   = r_addr[iplpm_pkg::IDX_W-1:0];

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_cmp_v = 1'b0;
                if (i_req.start) begin
                    n_dest  = i_req.dest;
                    n_limit = i_req.limit;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_mask  = '0;
                    n_hop   = '0;
                    n_port  = '0;
                    n_state = (i_req.limit == '0) ? S_HOLD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_rd.en = (r_addr != r_limit);
                n_cmp_v = (r_addr != r_limit);
                if (r_addr != r_limit) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_cmp_v && match && better) begin
                    n_found = 1'b1;
                    n_mask  = i_rd_data.mask;
                    n_hop   = i_rd_data.hop;
                    n_port  = i_rd_data.port;
                end
                if ((r_addr == r_limit) && !r_cmp_v) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                n_cmp_v = 1'b0;
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.route_found = r_found;
                    n_out.hop_addr    = r_hop;
                    n_out.out_port    = r_port;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cmp_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_dest  <= n_dest;
        r_limit <= n_limit;
        r_addr  <= n_addr;
        r_found <= n_found;
        r_mask  <= n_mask;
        r_hop   <= n_hop;
        r_port  <= n_port;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

[hw/rtl/ipv4_longest_prefix_route_lookup_unit.sv]
// top level of the ipv4 longest prefix route lookup unit
// depends on iplpm_pkg, iplpm_table, iplpm_scan
//
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in_req   (iplpm_pkg::t_in_req)
// out     | output    | o_out_valid / i_out_ready  | o_out_res  (iplpm_pkg::t_result)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (active_routes)
//
// a write request is stored as it is taken; a lookup scans n = min(active_routes, ROUTES) entries,
// skipping the scan when n is zero, and the next request waits for the scan, which is paced
// by the single one-entry-a-cycle read port
// a new request is taken as soon as the scan is done, while the result waits in its register
// a finished scan holds until the result register is free
// reset clears control and active_routes; the table itself is not cleared
`default_nettype none

module ipv4_longest_prefix_route_lookup_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  iplpm_pkg::t_in_req         i_in_req,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output iplpm_pkg::t_result               o_out_res,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [iplpm_pkg::ACT_W-1:0]      i_cfg_data
);

    logic [iplpm_pkg::ACT_W-1:0]  r_active;
    logic                         in_fire;
    logic                         wr_en;
    iplpm_pkg::t_entry            wr_data;
    iplpm_pkg::t_scan_req         scan_req;
    iplpm_pkg::t_rd_req           rd_req;
    iplpm_pkg::t_entry            rd_data;
    logic                         busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !busy;
    assign in_fire     = i_in_valid && o_in_ready;

    assign wr_en = in_fire && (i_in_req.kind == iplpm_pkg::KIND_WRITE)
                   && (32'(i_in_req.entry_index) < 32'(iplpm_pkg::ROUTES));
    assign wr_data.prefix = i_in_req.route_prefix;
    assign wr_data.mask   = i_in_req.route_mask;
    assign wr_data.hop    = i_in_req.route_gateway;
    assign wr_data.port   = i_in_req.route_port;

    assign scan_req.start = in_fire && (i_in_req.kind == iplpm_pkg::KIND_LOOKUP);
    assign scan_req.dest  = i_in_req.dest_address;
    assign scan_req.limit = (32'(r_active) > 32'(iplpm_pkg::ROUTES))
                            ? iplpm_pkg::CNT_W'(iplpm_pkg::ROUTES)
                            : iplpm_pkg::CNT_W'(r_active);

    iplpm_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (iplpm_pkg::IDX_W'(i_in_req.entry_index)),
        .i_wr_data (wr_data),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    iplpm_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (scan_req),
        .o_busy      (busy),
        .o_rd        (rd_req),
        .i_rd_data   (rd_data),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (o_out_res)
    );

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.route_found)
        |-> (o_out_res.hop_addr == '0) && (o_out_res.out_port == '0))
        else $error("miss result carries nonzero hop or port");

    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_req.kind == iplpm_pkg::KIND_LOOKUP)) |=> !o_in_ready)
        else $error("request taken during a running lookup");

    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_active == $past(i_cfg_data)))
        else $error("active_routes not updated");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !rd_req.en)
        else $error("table read outside a scan");

endmodule

`default_nettype wire
